>>> design/plob_pkg.sv
package plob_pkg;

  localparam int SYM_W = 4;
  localparam int SEQ_W = 63;
  localparam int TM_W  = 48;
  localparam int PX_W  = 48;
  localparam int IDX_W = 4;

  localparam logic [1:0] KIND_DEPTH  = 2'd0;
  localparam logic [1:0] KIND_TICKER = 2'd1;
  localparam logic [1:0] KIND_TRADE  = 2'd2;
  localparam logic [1:0] KIND_BAD    = 2'd3;

  localparam logic [1:0] REC_TRADE = 2'd0;
  localparam logic [1:0] REC_BID   = 2'd1;
  localparam logic [1:0] REC_ASK   = 2'd2;
  localparam logic [1:0] REC_EMPTY = 2'd3;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [SYM_W-1:0] symbol;
    logic [SEQ_W-1:0] sequence_req;
    logic [TM_W-1:0]  evt_time;
    logic             side;
    logic [PX_W-1:0]  price;
    logic [PX_W-1:0]  quantity;
    logic             level_valid;
    logic             buyer_maker;
    logic             first_item;
    logic             last_item;
  } item_t;

  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic [SEQ_W-1:0] out_sequence;
    logic [TM_W-1:0]  out_event_time;
    logic             update_kind;
    logic [1:0]       record_type;
    logic [IDX_W-1:0] level_index;
    logic [PX_W-1:0]  out_price;
    logic [PX_W-1:0]  out_quantity;
    logic             out_buyer_maker;
    logic             last_record;
  } rec_t;

  typedef struct packed {
    logic [PX_W-1:0] price;
    logic [PX_W-1:0] qty;
  } entry_t;

  typedef struct packed {
    logic load;
    logic seq_rd;
    logic seq_chk;
    logic clr_acc;
    logic srch_init;
    logic pos_inc;
    logic rd_pos;
    logic upd_qty;
    logic del_init;
    logic rd_jp1;
    logic del_step;
    logic del_final;
    logic ins_init;
    logic rd_jm1;
    logic ins_step;
    logic ins_final;
    logic emit_init;
    logic e_switch;
    logic rd_emit;
    logic out_trade;
    logic out_empty;
    logic out_level;
  } cmd_t;

  typedef struct packed {
    logic sym_ok;
    logic first;
    logic last;
    logic kind_trade;
    logic kind_bad;
    logic lvalid;
    logic qty_zero;
    logic msg_acc;
    logic pos_lt_n;
    logic better;
    logic price_eq;
    logic pos_lt_depth;
    logic j_gt_pos;
    logic jp1_lt_n;
    logic out_free;
    logic book_empty;
    logic bp;
    logic e_end;
    logic e_side;
  } stat_t;

endpackage

>>> design/plob_if.sv
interface plob_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [plob_pkg::SYM_W-1:0]   symbol;
  logic [plob_pkg::SEQ_W-1:0]   sequence_req;
  logic [plob_pkg::TM_W-1:0]    evt_time;
  logic                         side;
  logic [plob_pkg::PX_W-1:0]    price;
  logic [plob_pkg::PX_W-1:0]    quantity;
  logic                         level_valid;
  logic                         buyer_maker;
  logic                         first_item;
  logic                         last_item;

  modport source (output valid, req_type, symbol, sequence_req, evt_time, side, price,
                  quantity, level_valid, buyer_maker, first_item, last_item, input ready);
  modport sink (input valid, req_type, symbol, sequence_req, evt_time, side, price,
                quantity, level_valid, buyer_maker, first_item, last_item, output ready);
endinterface

interface plob_out_if;
  logic                         valid;
  logic                         ready;
  logic [plob_pkg::SYM_W-1:0]   out_symbol;
  logic [plob_pkg::SEQ_W-1:0]   out_sequence;
  logic [plob_pkg::TM_W-1:0]    out_event_time;
  logic                         update_kind;
  logic [1:0]                   record_type;
  logic [plob_pkg::IDX_W-1:0]   level_index;
  logic [plob_pkg::PX_W-1:0]    out_price;
  logic [plob_pkg::PX_W-1:0]    out_quantity;
  logic                         out_buyer_maker;
  logic                         last_record;

  modport source (output valid, out_symbol, out_sequence, out_event_time, update_kind,
                  record_type, level_index, out_price, out_quantity, out_buyer_maker,
                  last_record, input ready);
  modport sink (input valid, out_symbol, out_sequence, out_event_time, update_kind,
                record_type, level_index, out_price, out_quantity, out_buyer_maker,
                last_record, output ready);
endinterface

>>> design/plob_ctrl.sv
module plob_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  plob_pkg::stat_t st,
  output plob_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    IDLE, SEQ_RD, SEQ_CHK, GATE, SRCH_RD, SRCH_CHK, HIT, MISS,
    DEL_RD, DEL_WR, INS_RD, INS_WR, DONE_LVL,
    EMIT_INIT, EMIT_TRADE, EMIT_EMPTY, EMIT_NEXT, EMIT_LOAD
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = SEQ_RD;
        end
      end
      SEQ_RD: begin
        if (!st.sym_ok) begin
          state_nxt = IDLE;
        end else if (st.first && st.kind_bad) begin
          cmd.clr_acc = 1'b1;
          state_nxt = IDLE;
        end else if (st.first) begin
          cmd.seq_rd = 1'b1;
          state_nxt = SEQ_CHK;
        end else begin
          state_nxt = GATE;
        end
      end
      SEQ_CHK: begin
        cmd.seq_chk = 1'b1;
        state_nxt = GATE;
      end
      GATE: begin
        if (st.kind_bad || !st.msg_acc) begin
          state_nxt = IDLE;
        end else if (!st.kind_trade && st.lvalid) begin
          cmd.srch_init = 1'b1;
          state_nxt = SRCH_RD;
        end else if (st.last) begin
          state_nxt = EMIT_INIT;
        end else begin
          state_nxt = IDLE;
        end
      end
      SRCH_RD: begin
        if (st.pos_lt_n) begin
          cmd.rd_pos = 1'b1;
          state_nxt = SRCH_CHK;
        end else begin
          state_nxt = MISS;
        end
      end
      SRCH_CHK: begin
        if (st.better) begin
          cmd.pos_inc = 1'b1;
          state_nxt = SRCH_RD;
        end else if (st.price_eq) begin
          state_nxt = HIT;
        end else begin
          state_nxt = MISS;
        end
      end
      HIT: begin
        if (st.qty_zero) begin
          cmd.del_init = 1'b1;
          state_nxt = DEL_RD;
        end else begin
          cmd.upd_qty = 1'b1;
          state_nxt = DONE_LVL;
        end
      end
      DEL_RD: begin
        if (st.jp1_lt_n) begin
          cmd.rd_jp1 = 1'b1;
          state_nxt = DEL_WR;
        end else begin
          cmd.del_final = 1'b1;
          state_nxt = DONE_LVL;
        end
      end
      DEL_WR: begin
        cmd.del_step = 1'b1;
        state_nxt = DEL_RD;
      end
      MISS: begin
        if (!st.qty_zero && st.pos_lt_depth) begin
          cmd.ins_init = 1'b1;
          state_nxt = INS_RD;
        end else begin
          state_nxt = DONE_LVL;
        end
      end
      INS_RD: begin
        if (st.j_gt_pos) begin
          cmd.rd_jm1 = 1'b1;
          state_nxt = INS_WR;
        end else begin
          cmd.ins_final = 1'b1;
          state_nxt = DONE_LVL;
        end
      end
      INS_WR: begin
        cmd.ins_step = 1'b1;
        state_nxt = INS_RD;
      end
      DONE_LVL: begin
        state_nxt = st.last ? EMIT_INIT : IDLE;
      end
      EMIT_INIT: begin
        cmd.emit_init = 1'b1;
        if (st.kind_trade) begin
          state_nxt = EMIT_TRADE;
        end else if (st.book_empty) begin
          state_nxt = EMIT_EMPTY;
        end else begin
          state_nxt = EMIT_NEXT;
        end
      end
      EMIT_TRADE: begin
        if (st.out_free) begin
          cmd.out_trade = 1'b1;
          state_nxt = st.bp ? EMIT_NEXT : IDLE;
        end
      end
      EMIT_EMPTY: begin
        if (st.out_free) begin
          cmd.out_empty = 1'b1;
          state_nxt = IDLE;
        end
      end
      EMIT_NEXT: begin
        if (st.e_end) begin
          if (!st.e_side) begin
            cmd.e_switch = 1'b1;
          end else begin
            state_nxt = IDLE;
          end
        end else if (st.out_free) begin
          cmd.rd_emit = 1'b1;
          state_nxt = EMIT_LOAD;
        end
      end
      EMIT_LOAD: begin
        // output register was free when the read issued, so it is free now
        cmd.out_level = 1'b1;
        state_nxt = EMIT_NEXT;
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/plob_dp.sv
module plob_dp #(
  parameter int NUM_SYMBOLS = 16,
  parameter int BOOK_DEPTH  = 64,
  parameter int TOP_LEVELS  = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  plob_pkg::item_t in_item,
  input  plob_pkg::cmd_t  cmd,
  output plob_pkg::stat_t st,
  output plob_pkg::rec_t  out_rec,
  output logic            out_valid,
  input  logic            out_ready
);

  localparam int SW  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int PW  = $clog2(BOOK_DEPTH);
  localparam int CW  = $clog2(BOOK_DEPTH + 1);
  localparam int EW  = $clog2(TOP_LEVELS + 1);
  localparam int MW  = (CW > EW) ? CW : EW;
  localparam int AW  = 1 + SW + PW;
  localparam int SQN = NUM_SYMBOLS * 3;
  localparam int SQW = (SQN > 1) ? $clog2(SQN) : 1;
  localparam int SQX = SQW + 2;

  plob_pkg::item_t  item_r;
  logic             msg_acc_r;
  logic             book_present_r [NUM_SYMBOLS];
  logic [CW-1:0]    cnt_r [NUM_SYMBOLS][2];

  logic [plob_pkg::SEQ_W-1:0] seq_mem [SQN];
  logic                       seq_vld_r [SQN];
  logic [plob_pkg::SEQ_W-1:0] seq_rdata_r;
  logic                       seq_rvld_r;

  plob_pkg::entry_t book_mem [2**AW];
  plob_pkg::entry_t rdata_r;

  logic [CW-1:0]    pos_r, j_r, n_r;
  logic             e_side_r;
  logic [EW-1:0]    e_i_r;
  plob_pkg::rec_t   out_rec_r;
  logic             out_valid_r;

  logic [SW-1:0]    sym_idx;
  logic [SQW-1:0]   seq_addr;
  logic [CW-1:0]    cur_cnt;
  logic [EW-1:0]    nb, na;
  logic [MW-1:0]    cnt_b_m, cnt_a_m;
  logic [plob_pkg::SEQ_W-1:0] seq_stored;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             rd_en, wr_en;
  plob_pkg::entry_t wr_data;
  logic [CW-1:0]    n_ins;
  logic             lvl_last;

  assign sym_idx  = SW'(item_r.symbol);
  assign seq_addr = SQW'(SQX'(sym_idx) * SQX'(3) + SQX'(item_r.req_type));
  assign cur_cnt  = cnt_r[sym_idx][item_r.side];
  assign cnt_b_m  = MW'(cnt_r[sym_idx][plob_pkg::SIDE_BID]);
  assign cnt_a_m  = MW'(cnt_r[sym_idx][plob_pkg::SIDE_ASK]);
  assign nb = (cnt_b_m > MW'(TOP_LEVELS)) ? EW'(TOP_LEVELS) : EW'(cnt_b_m);
  assign na = (cnt_a_m > MW'(TOP_LEVELS)) ? EW'(TOP_LEVELS) : EW'(cnt_a_m);
  assign seq_stored = seq_rvld_r ? seq_rdata_r : '0;
  assign n_ins = (n_r == CW'(BOOK_DEPTH)) ? CW'(BOOK_DEPTH - 1) : n_r;
  assign lvl_last = e_side_r ? ((e_i_r + EW'(1)) == na)
                             : (((e_i_r + EW'(1)) == nb) && (na == '0));

  always_comb begin
    st.sym_ok       = (9'(item_r.symbol) < 9'(NUM_SYMBOLS));
    st.first        = item_r.first_item;
    st.last         = item_r.last_item;
    st.kind_trade   = (item_r.req_type == plob_pkg::KIND_TRADE);
    st.kind_bad     = (item_r.req_type == plob_pkg::KIND_BAD);
    st.lvalid       = item_r.level_valid;
    st.qty_zero     = (item_r.quantity == '0);
    st.msg_acc      = msg_acc_r;
    st.pos_lt_n     = (pos_r < n_r);
    st.better       = item_r.side ? (rdata_r.price < item_r.price)
                                  : (rdata_r.price > item_r.price);
    st.price_eq     = (rdata_r.price == item_r.price);
    st.pos_lt_depth = (pos_r < CW'(BOOK_DEPTH));
    st.j_gt_pos     = (j_r > pos_r);
    st.jp1_lt_n     = ((j_r + CW'(1)) < n_r);
    st.out_free     = !out_valid_r || out_ready;
    st.book_empty   = (nb == '0) && (na == '0);
    st.bp           = book_present_r[sym_idx];
    st.e_end        = e_side_r ? (e_i_r >= na) : (e_i_r >= nb);
    st.e_side       = e_side_r;
  end

  // book memory ports
  always_comb begin
    rd_addr = {item_r.side, sym_idx, pos_r[PW-1:0]};
    if (cmd.rd_jp1) begin
      rd_addr = {item_r.side, sym_idx, PW'(j_r + CW'(1))};
    end else if (cmd.rd_jm1) begin
      rd_addr = {item_r.side, sym_idx, PW'(j_r - CW'(1))};
    end else if (cmd.rd_emit) begin
      rd_addr = {e_side_r, sym_idx, PW'(e_i_r)};
    end
    rd_en = cmd.rd_pos | cmd.rd_jp1 | cmd.rd_jm1 | cmd.rd_emit;

    wr_en   = cmd.del_step | cmd.ins_step | cmd.upd_qty | cmd.ins_final;
    wr_addr = {item_r.side, sym_idx, j_r[PW-1:0]};
    wr_data = rdata_r;
    if (cmd.upd_qty || cmd.ins_final) begin
      wr_addr = {item_r.side, sym_idx, pos_r[PW-1:0]};
      wr_data = '{price: item_r.price, qty: item_r.quantity};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      book_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= book_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seq_chk && (item_r.sequence_req > seq_stored)) begin
      seq_mem[seq_addr] <= item_r.sequence_req;
    end
    if (cmd.seq_rd) begin
      seq_rdata_r <= seq_mem[seq_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.srch_init) begin
      pos_r <= '0;
      n_r   <= cur_cnt;
    end
    if (cmd.pos_inc) begin
      pos_r <= pos_r + CW'(1);
    end
    if (cmd.del_init) begin
      j_r <= pos_r;
    end
    if (cmd.del_step) begin
      j_r <= j_r + CW'(1);
    end
    if (cmd.ins_init) begin
      n_r <= n_ins;
      j_r <= n_ins;
    end
    if (cmd.ins_step) begin
      j_r <= j_r - CW'(1);
    end
    if (cmd.emit_init) begin
      e_side_r <= plob_pkg::SIDE_BID;
      e_i_r    <= '0;
    end
    if (cmd.e_switch) begin
      e_side_r <= plob_pkg::SIDE_ASK;
      e_i_r    <= '0;
    end
    if (cmd.out_level) begin
      e_i_r <= e_i_r + EW'(1);
    end
    if (cmd.out_trade) begin
      out_rec_r <= '{out_symbol: item_r.symbol, out_sequence: item_r.sequence_req,
                     out_event_time: item_r.evt_time, update_kind: 1'b1,
                     record_type: plob_pkg::REC_TRADE, level_index: '0,
                     out_price: item_r.price, out_quantity: item_r.quantity,
                     out_buyer_maker: item_r.buyer_maker,
                     last_record: !st.bp || st.book_empty};
    end else if (cmd.out_empty) begin
      out_rec_r <= '{out_symbol: item_r.symbol, out_sequence: item_r.sequence_req,
                     out_event_time: item_r.evt_time, update_kind: 1'b0,
                     record_type: plob_pkg::REC_EMPTY, level_index: '0,
                     out_price: '0, out_quantity: '0, out_buyer_maker: 1'b0,
                     last_record: 1'b1};
    end else if (cmd.out_level) begin
      out_rec_r <= '{out_symbol: item_r.symbol, out_sequence: item_r.sequence_req,
                     out_event_time: item_r.evt_time,
                     update_kind: (item_r.req_type == plob_pkg::KIND_TRADE),
                     record_type: e_side_r ? plob_pkg::REC_ASK : plob_pkg::REC_BID,
                     level_index: plob_pkg::IDX_W'(e_i_r),
                     out_price: rdata_r.price, out_quantity: rdata_r.qty,
                     out_buyer_maker: 1'b0, last_record: lvl_last};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_acc_r   <= 1'b0;
      out_valid_r <= 1'b0;
      seq_rvld_r  <= 1'b0;
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
        book_present_r[s] <= 1'b0;
        cnt_r[s][0] <= '0;
        cnt_r[s][1] <= '0;
      end
      for (int k = 0; k < SQN; k++) begin
        seq_vld_r[k] <= 1'b0;
      end
    end else begin
      if (cmd.clr_acc) begin
        msg_acc_r <= 1'b0;
      end
      if (cmd.seq_rd) begin
        seq_rvld_r <= seq_vld_r[seq_addr];
      end
      if (cmd.seq_chk) begin
        if (item_r.sequence_req > seq_stored) begin
          seq_vld_r[seq_addr] <= 1'b1;
          msg_acc_r <= 1'b1;
          if (item_r.req_type != plob_pkg::KIND_TRADE) begin
            book_present_r[sym_idx] <= 1'b1;
          end
        end else begin
          msg_acc_r <= 1'b0;
        end
      end
      if (cmd.del_final) begin
        cnt_r[sym_idx][item_r.side] <= n_r - CW'(1);
      end
      if (cmd.ins_final) begin
        cnt_r[sym_idx][item_r.side] <= n_r + CW'(1);
      end
      if (cmd.out_trade || cmd.out_empty || cmd.out_level) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_rec   = out_rec_r;
  assign out_valid = out_valid_r;

endmodule

>>> design/price_level_order_book_top.sv
// Operation: the sorted search reads and checks the stored levels one at a time, and an insert
//   or delete shifts the levels one at a time through the single book read port.
// Snapshot: setup and side switching, one read per level record, the trade or empty-book
//   record, plus output stalls; up to 2*TOP_LEVELS+1 records.
// Input: one item at a time; a new item is taken only while the controller is idle.
// Reset (rst_n low, synchronous): sequences, level counts, book flags, output cleared at once.
module price_level_order_book_top #(
  parameter int NUM_SYMBOLS = 16,
  parameter int BOOK_DEPTH  = 64,
  parameter int TOP_LEVELS  = 10
) (
  input logic       clk,
  input logic       rst_n,
  plob_in_if.sink   in_ch,
  plob_out_if.source out_ch
);

  plob_pkg::item_t in_item;
  plob_pkg::rec_t  out_rec;
  plob_pkg::cmd_t  cmd;
  plob_pkg::stat_t st;

  assign in_item = '{req_type: in_ch.req_type, symbol: in_ch.symbol,
                     sequence_req: in_ch.sequence_req, evt_time: in_ch.evt_time,
                     side: in_ch.side, price: in_ch.price, quantity: in_ch.quantity,
                     level_valid: in_ch.level_valid, buyer_maker: in_ch.buyer_maker,
                     first_item: in_ch.first_item, last_item: in_ch.last_item};

  plob_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  plob_dp #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .BOOK_DEPTH  (BOOK_DEPTH),
    .TOP_LEVELS  (TOP_LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_rec   (out_rec),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

  assign out_ch.out_symbol      = out_rec.out_symbol;
  assign out_ch.out_sequence    = out_rec.out_sequence;
  assign out_ch.out_event_time  = out_rec.out_event_time;
  assign out_ch.update_kind     = out_rec.update_kind;
  assign out_ch.record_type     = out_rec.record_type;
  assign out_ch.level_index     = out_rec.level_index;
  assign out_ch.out_price       = out_rec.out_price;
  assign out_ch.out_quantity    = out_rec.out_quantity;
  assign out_ch.out_buyer_maker = out_rec.out_buyer_maker;
  assign out_ch.last_record     = out_rec.last_record;

`ifndef NO_ASSERTIONS
  // an accepted transaction always occupies the controller for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.record_type == plob_pkg::REC_EMPTY |->
      out_ch.last_record && !out_ch.update_kind)
    else $error("empty-book record not final");

  a_trade_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.record_type == plob_pkg::REC_TRADE |-> out_ch.update_kind)
    else $error("trade record with book update kind");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int NSYM  = 16;
  localparam int DEPTH = 64;
  localparam int TOPN  = 10;

  localparam int SYM_W = plob_pkg::SYM_W;
  localparam int SEQ_W = plob_pkg::SEQ_W;
  localparam int TM_W  = plob_pkg::TM_W;
  localparam int PX_W  = plob_pkg::PX_W;
  localparam int IDX_W = plob_pkg::IDX_W;

  localparam logic [1:0] K_DEPTH  = plob_pkg::KIND_DEPTH;
  localparam logic [1:0] K_TICKER = plob_pkg::KIND_TICKER;
  localparam logic [1:0] K_TRADE  = plob_pkg::KIND_TRADE;
  localparam logic [1:0] K_BAD    = plob_pkg::KIND_BAD;
  localparam logic [1:0] R_TRADE  = plob_pkg::REC_TRADE;
  localparam logic [1:0] R_BID    = plob_pkg::REC_BID;
  localparam logic [1:0] R_ASK    = plob_pkg::REC_ASK;
  localparam logic [1:0] R_EMPTY  = plob_pkg::REC_EMPTY;
  localparam logic       S_BID    = plob_pkg::SIDE_BID;
  localparam logic       S_ASK    = plob_pkg::SIDE_ASK;

  logic clk;
  logic rst_n;

  plob_in_if  in_ch ();
  plob_out_if out_ch ();

  price_level_order_book_top #(
    .NUM_SYMBOLS(NSYM),
    .BOOK_DEPTH (DEPTH),
    .TOP_LEVELS (TOPN)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // book predictor state
  logic [SEQ_W-1:0]  last_seq [NSYM*3];
  bit                book_seen [NSYM];
  plob_pkg::entry_t  levels [NSYM*2][$];
  bit                msg_ok;

  plob_pkg::rec_t pending_recs [$];
  int   n_err;
  int   in_idle_pct;
  int   out_stall_pct;

  task automatic report_mismatch(input string what);
    n_err++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic bit price_better(input logic sd, input logic [PX_W-1:0] a,
                                      input logic [PX_W-1:0] b);
    return sd ? (a < b) : (a > b);
  endfunction

  function automatic void book_apply(input int sym, input logic sd,
                                     input logic [PX_W-1:0] px, input logic [PX_W-1:0] qty);
    int k;
    int pos;
    plob_pkg::entry_t e;
    k = sym * 2 + sd;
    pos = 0;
    while (pos < levels[k].size() && price_better(sd, levels[k][pos].price, px)) pos++;
    if (pos < levels[k].size() && levels[k][pos].price == px) begin
      if (qty == 0) levels[k].delete(pos);
      else levels[k][pos].qty = qty;
    end else if (qty != 0 && pos < DEPTH) begin
      // full side: worst level falls off
      if (levels[k].size() == DEPTH) void'(levels[k].pop_back());
      e.price = px;
      e.qty = qty;
      levels[k].insert(pos, e);
    end
  endfunction

  function automatic plob_pkg::rec_t make_rec(input plob_pkg::item_t it, input logic kd,
                                              input logic [1:0] rt, input int idx,
                                              input logic [PX_W-1:0] px,
                                              input logic [PX_W-1:0] qty, input logic bm);
    plob_pkg::rec_t r;
    r.out_symbol      = it.symbol;
    r.out_sequence    = it.sequence_req;
    r.out_event_time  = it.evt_time;
    r.update_kind     = kd;
    r.record_type     = rt;
    r.level_index     = idx[IDX_W-1:0];
    r.out_price       = px;
    r.out_quantity    = qty;
    r.out_buyer_maker = bm;
    r.last_record     = 1'b0;
    return r;
  endfunction

  // advances the book by one transaction, returns the records it produces
  function automatic void book_step(input plob_pkg::item_t it, output plob_pkg::rec_t recs[$]);
    int sym;
    logic kd;
    recs = {};
    sym = it.symbol;
    if (it.first_item) begin
      if (it.req_type == K_BAD) msg_ok = 1'b0;
      else if (it.sequence_req > last_seq[sym*3 + it.req_type]) begin
        last_seq[sym*3 + it.req_type] = it.sequence_req;
        msg_ok = 1'b1;
        if (it.req_type != K_TRADE) book_seen[sym] = 1'b1;
      end else msg_ok = 1'b0;
    end
    if (it.req_type == K_BAD || !msg_ok) return;
    if (it.req_type != K_TRADE && it.level_valid)
      book_apply(sym, it.side, it.price, it.quantity);
    if (!it.last_item) return;
    kd = (it.req_type == K_TRADE);
    if (kd) recs = {recs, make_rec(it, 1'b1, R_TRADE, 0, it.price, it.quantity,
                                   it.buyer_maker)};
    if (!kd || book_seen[sym]) begin
      for (int s = 0; s < 2; s++)
        for (int i = 0; i < levels[sym*2+s].size() && i < TOPN; i++)
          recs = {recs, make_rec(it, kd, s ? R_ASK : R_BID, i,
                                 levels[sym*2+s][i].price, levels[sym*2+s][i].qty, 1'b0)};
    end
    if (recs.size() == 0) recs = {recs, make_rec(it, 1'b0, R_EMPTY, 0, 0, 0, 1'b0)};
    recs[recs.size()-1].last_record = 1'b1;
  endfunction

  task automatic send_item(input plob_pkg::item_t it, output plob_pkg::rec_t recs[$]);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= it.req_type;
    in_ch.symbol        <= it.symbol;
    in_ch.sequence_req  <= it.sequence_req;
    in_ch.evt_time      <= it.evt_time;
    in_ch.side          <= it.side;
    in_ch.price         <= it.price;
    in_ch.quantity      <= it.quantity;
    in_ch.level_valid   <= it.level_valid;
    in_ch.buyer_maker   <= it.buyer_maker;
    in_ch.first_item    <= it.first_item;
    in_ch.last_item     <= it.last_item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    book_step(it, recs);
    pending_recs = {pending_recs, recs};
  endtask

  function automatic plob_pkg::item_t mk(input logic [1:0] kd, input int sym,
                                         input logic [SEQ_W-1:0] sq,
                                         input logic [TM_W-1:0] tm, input logic sd,
                                         input logic [PX_W-1:0] px,
                                         input logic [PX_W-1:0] qty, input logic lv,
                                         input logic bm, input logic f, input logic l);
    plob_pkg::item_t it;
    it.req_type = kd;
    it.symbol = sym[SYM_W-1:0];
    it.sequence_req = sq;
    it.evt_time = tm;
    it.side = sd;
    it.price = px;
    it.quantity = qty;
    it.level_valid = lv;
    it.buyer_maker = bm;
    it.first_item = f;
    it.last_item = l;
    return it;
  endfunction

  // result monitor
  always @(posedge clk) begin
    plob_pkg::rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_recs.size() == 0) report_mismatch("record with nothing expected");
      else begin
        want = pending_recs.pop_front();
        if (out_ch.out_symbol !== want.out_symbol)
          report_mismatch($sformatf("symbol %0d want %0d", out_ch.out_symbol, want.out_symbol));
        if (out_ch.out_sequence !== want.out_sequence)
          report_mismatch($sformatf("sequence %0h want %0h", out_ch.out_sequence,
                                    want.out_sequence));
        if (out_ch.out_event_time !== want.out_event_time)
          report_mismatch($sformatf("event time %0h want %0h", out_ch.out_event_time,
                                    want.out_event_time));
        if (out_ch.update_kind !== want.update_kind)
          report_mismatch($sformatf("update kind %0b want %0b", out_ch.update_kind,
                                    want.update_kind));
        if (out_ch.record_type !== want.record_type)
          report_mismatch($sformatf("record type %0d want %0d", out_ch.record_type,
                                    want.record_type));
        if (out_ch.level_index !== want.level_index)
          report_mismatch($sformatf("level index %0d want %0d", out_ch.level_index,
                                    want.level_index));
        if (out_ch.out_price !== want.out_price)
          report_mismatch($sformatf("price %0h want %0h", out_ch.out_price, want.out_price));
        if (out_ch.out_quantity !== want.out_quantity)
          report_mismatch($sformatf("quantity %0h want %0h", out_ch.out_quantity,
                                    want.out_quantity));
        if (out_ch.out_buyer_maker !== want.out_buyer_maker)
          report_mismatch($sformatf("buyer maker %0b want %0b", out_ch.out_buyer_maker,
                                    want.out_buyer_maker));
        if (out_ch.last_record !== want.last_record)
          report_mismatch($sformatf("last record %0b want %0b", out_ch.last_record,
                                    want.last_record));
      end
    end
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= out_stall_pct);

  typedef struct {
    plob_pkg::item_t it;
    bit              typed;
    plob_pkg::rec_t  first_rec;
  } dir_row_t;

  localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};
  localparam logic [PX_W-1:0]  PX_MAX  = {PX_W{1'b1}};

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    plob_pkg::rec_t recs [$];
    logic [SEQ_W-1:0] next_seq [NSYM*3];
    plob_pkg::item_t it;
    int phase_pct [4][2];
    int sym;
    int kd;
    int len;
    int waited;

    phase_pct = '{'{0, 0}, '{73, 0}, '{0, 73}, '{7, 7}};
    n_err = 0;
    msg_ok = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    foreach (last_seq[i]) begin
      last_seq[i] = '0;
      next_seq[i] = 1;
    end
    foreach (book_seen[i]) book_seen[i] = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    it = '0;
    in_ch.req_type <= '0; in_ch.symbol <= '0; in_ch.sequence_req <= '0;
    in_ch.evt_time <= '0; in_ch.side <= '0; in_ch.price <= '0; in_ch.quantity <= '0;
    in_ch.level_valid <= '0; in_ch.buyer_maker <= '0; in_ch.first_item <= '0;
    in_ch.last_item <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; typed first record where it is obvious
    row.typed = 0; row.first_rec = '0;
    row.it = mk(K_DEPTH, 0, 0, 5, S_BID, 10, 1, 1, 0, 1, 1); rows = {rows, row};
    row.it = mk(K_DEPTH, 0, 1, 0, S_BID, 0, 0, 0, 0, 1, 1);
    row.typed = 1;
    row.first_rec = make_rec(row.it, 1'b0, R_EMPTY, 0, 0, 0, 1'b0);
    row.first_rec.last_record = 1'b1;
    rows = {rows, row}; row.typed = 0;
    row.it = mk(K_DEPTH, 0, 2, 7, S_BID, 100, 5, 1, 0, 1, 0); rows = {rows, row};
    row.it = mk(K_DEPTH, 0, 2, 7, S_ASK, 200, 7, 1, 0, 0, 1); rows = {rows, row};
    row.it = mk(K_TICKER, 0, 1, PX_MAX, S_BID, PX_MAX, PX_MAX, 1, 1, 1, 1);
    rows = {rows, row};
    row.it = mk(K_TRADE, 0, 1, 9, S_ASK, PX_MAX, PX_MAX, 1, 1, 1, 1);
    row.typed = 1;
    row.first_rec = make_rec(row.it, 1'b1, R_TRADE, 0, PX_MAX, PX_MAX, 1'b1);
    rows = {rows, row};
    row.it = mk(K_TRADE, 1, SEQ_MAX, PX_MAX, S_BID, 3, 4, 0, 0, 1, 1);
    row.first_rec = make_rec(row.it, 1'b1, R_TRADE, 0, 3, 4, 1'b0);
    row.first_rec.last_record = 1'b1;
    rows = {rows, row}; row.typed = 0;
    row.it = mk(K_TRADE, 1, SEQ_MAX, 1, S_BID, 3, 4, 0, 0, 1, 1); rows = {rows, row};
    row.it = mk(K_BAD, 0, 50, 1, S_BID, 300, 1, 1, 0, 1, 1); rows = {rows, row};
    row.it = mk(K_DEPTH, 0, 9, 1, S_BID, 300, 1, 1, 0, 0, 1); rows = {rows, row};
    row.it = mk(K_DEPTH, 0, 3, 2, S_BID, 100, 0, 1, 0, 1, 0); rows = {rows, row};
    row.it = mk(K_DEPTH, 0, 3, 2, S_ASK, 999, 0, 1, 0, 0, 0); rows = {rows, row};
    row.it = mk(K_DEPTH, 0, 3, 2, S_ASK, 150, 2, 1, 0, 0, 0); rows = {rows, row};
    row.it = mk(K_TRADE, 0, 3, 2, S_ASK, 160, 2, 1, 0, 0, 0); rows = {rows, row};
    row.it = mk(K_DEPTH, 0, 3, 2, S_ASK, 150, 8, 1, 0, 0, 1); rows = {rows, row};
    row.it = mk(K_DEPTH, 15, SEQ_MAX, PX_MAX, S_BID, 0, 1, 1, 0, 1, 1);
    rows = {rows, row};
    row.it = mk(K_TICKER, 15, 4, 0, S_ASK, PX_MAX, 1, 1, 0, 1, 1); rows = {rows, row};
    row.it = mk(K_TICKER, 15, 4, 0, S_ASK, 5, 1, 1, 0, 1, 1); rows = {rows, row};

    foreach (rows[r]) begin
      send_item(rows[r].it, recs);
      if (rows[r].typed && (recs.size() == 0 || recs[0] != rows[r].first_rec))
        report_mismatch($sformatf("directed row %0d: predicted first record differs", r));
    end
    foreach (last_seq[i]) next_seq[i] = last_seq[i] + 1;

    // fill both sides of symbol 2 beyond the kept depth, then drop and push out levels
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < DEPTH + 6; i++) begin
        it = mk(K_DEPTH, 2, SEQ_W'(1 + s), TM_W'(i), s[0],
                PX_W'(s ? 5000 - 10*i : 1000 + 10*i), PX_W'(i + 1), 1, 0,
                i == 0, i == DEPTH + 5);
        send_item(it, recs);
      end
    end
    it = mk(K_DEPTH, 2, 3, 0, S_BID, 1, 9, 1, 0, 1, 0); send_item(it, recs);
    it = mk(K_DEPTH, 2, 3, 0, S_ASK, 99999, 9, 1, 0, 0, 0); send_item(it, recs);
    it = mk(K_DEPTH, 2, 3, 0, S_BID, 1_000_000, 9, 1, 0, 0, 1); send_item(it, recs);
    next_seq[2*3 + K_DEPTH] = 4;

    // random messages, four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct = phase_pct[ph][0];
      out_stall_pct = phase_pct[ph][1];
      for (int m = 0; m < 13; m++) begin
        if ($urandom_range(9) == 0) begin
          // noise: arbitrary fields, possibly broken message framing
          it = mk(2'($urandom_range(3)), $urandom_range(15),
                  SEQ_W'({$urandom, $urandom}), TM_W'({$urandom, $urandom}),
                  1'($urandom_range(1)),
                  PX_W'({$urandom, $urandom}), PX_W'({$urandom, $urandom}),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
          if (it.first_item && it.req_type != K_BAD && it.symbol < 8)
            it.sequence_req = SEQ_W'($urandom_range(3));
          send_item(it, recs);
          foreach (last_seq[i]) if (next_seq[i] <= last_seq[i]) next_seq[i] = last_seq[i] + 1;
          continue;
        end
        sym = $urandom_range(9) < 7 ? $urandom_range(3) : $urandom_range(15);
        kd = $urandom_range(4) < 2 ? K_DEPTH : ($urandom_range(1) ? K_TICKER : K_TRADE);
        len = kd == K_TRADE ? 1 : $urandom_range(4, 1);
        for (int i = 0; i < len; i++) begin
          it = mk(2'(kd), sym, next_seq[sym*3 + kd],
                  TM_W'({$urandom_range(65535), $urandom}), 1'($urandom_range(1)),
                  PX_W'(1000 + 10 * $urandom_range(30)),
                  PX_W'($urandom_range(3) == 0 ? 0 : $urandom_range(1000, 1)),
                  $urandom_range(7) != 0, 1'($urandom_range(1)), i == 0, i == len - 1);
          if ($urandom_range(15) == 0) it.price = PX_W'({$urandom, $urandom});
          if ($urandom_range(15) == 0) it.quantity = PX_W'({$urandom, $urandom});
          if (i == 0 && $urandom_range(9) == 0) it.sequence_req = last_seq[sym*3 + kd];
          send_item(it, recs);
        end
        if (next_seq[sym*3 + kd] <= last_seq[sym*3 + kd])
          next_seq[sym*3 + kd] = last_seq[sym*3 + kd] + 1;
        next_seq[sym*3 + kd] += SEQ_W'($urandom_range(2));
      end
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (pending_recs.size() != 0 && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (400) @(posedge clk);
    if (n_err == 0 && pending_recs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_recs.size() != 0)
        report_mismatch($sformatf("%0d records never arrived", pending_recs.size()));
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
